FILE: rtl/e2c_pkg.sv
`timescale 1ns / 1ps

package e2c_pkg;

    localparam int FACE_SIZE_DEF  = 512;
    localparam int ANGLE_BITS_DEF = 18;
    localparam int PIXEL_BYTES    = 4;

    localparam int FACE_W   = 3;
    localparam int COL_W    = 9;
    localparam int WIDTH_W  = 14;
    localparam int HEIGHT_W = 13;
    localparam int PITCH_W  = 16;
    localparam int SRCX_W   = 13;
    localparam int SRCY_W   = 12;
    localparam int ADDR_W   = 27;
    localparam int DEST_W   = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // direction components hold +-2048 at the largest face size
    localparam int VEC_W     = 13;
    localparam int SQ_W      = 24;
    localparam int RAD_W     = 40;
    localparam int ISQ_STEPS = RAD_W / 2;
    localparam int ROOT_W    = ISQ_STEPS;
    localparam int CORDIC_W  = 40;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_SRC_PITCH  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic [COL_W-1:0]  col;
        logic [COL_W-1:0]  row;
    } in_t;

    typedef struct packed {
        logic [SRCX_W-1:0] src_x;
        logic [SRCY_W-1:0] src_y;
        logic [ADDR_W-1:0] src_address;
        logic [DEST_W-1:0] dest_offset;
    } out_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/e2c_delay.sv
`timescale 1ns / 1ps

module e2c_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];
endmodule

FILE: rtl/e2c_isqrt.sv
`timescale 1ns / 1ps

module e2c_isqrt (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [e2c_pkg::RAD_W-1:0]  rad,
    output logic [e2c_pkg::ROOT_W-1:0] root
);
    import e2c_pkg::*;

    logic [RAD_W-1:0] rem_reg  [0:ISQ_STEPS];
    logic [RAD_W-1:0] root_reg [0:ISQ_STEPS];

    assign rem_reg[0]  = rad;
    assign root_reg[0] = '0;

    // one result bit per stage, trial bit starting at 2^(RAD_W-2)
    for (genvar i = 0; i < ISQ_STEPS; i++) begin : g_step
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * i);
        logic [RAD_W-1:0] trial;
        assign trial = root_reg[i] + BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_reg[i] >= trial) begin
                    rem_reg[i+1]  <= rem_reg[i] - trial;
                    root_reg[i+1] <= (root_reg[i] >> 1) + BIT;
                end else begin
                    rem_reg[i+1]  <= rem_reg[i];
                    root_reg[i+1] <= root_reg[i] >> 1;
                end
            end
        end
    end

    assign root = root_reg[ISQ_STEPS][ROOT_W-1:0];
endmodule

FILE: rtl/e2c_cordic.sv
`timescale 1ns / 1ps

module e2c_cordic (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [e2c_pkg::CORDIC_W-1:0] x_in,
    input  logic signed [e2c_pkg::CORDIC_W-1:0] y_in,
    output logic [31:0]                         ang
);
    import e2c_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_reg [0:CORDIC_STEPS];
    logic [31:0]                a_reg [0:CORDIC_STEPS];
    logic                       z_reg [0:CORDIC_STEPS];
    logic [31:0]                ang_reg;

    // quarter-turn pre-rotation into the right half plane
    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0) begin
                if (y_in >= 0) begin
                    x_reg[0] <= y_in;
                    y_reg[0] <= -x_in;
                    a_reg[0] <= 32'h4000_0000;
                end else begin
                    x_reg[0] <= -y_in;
                    y_reg[0] <= x_in;
                    a_reg[0] <= 32'hC000_0000;
                end
            end else begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                a_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic [31:0] ATAN = atan_entry(i);
        logic signed [CORDIC_W-1:0] dx, dy;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                z_reg[i+1] <= z_reg[i];
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    a_reg[i+1] <= a_reg[i] + ATAN;
                end else begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    a_reg[i+1] <= a_reg[i] - ATAN;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= z_reg[CORDIC_STEPS] ? 32'd0
                     : ((a_reg[CORDIC_STEPS] + 32'd32) & 32'hFFFF_FFC0);
        end
    end

    assign ang = ang_reg;
endmodule

FILE: rtl/equirect_to_cubemap_lookup_unit.sv
`timescale 1ns / 1ps

// Pipeline stages from request accept to result valid: 1 face vector, 1 square sum,
//   20 square-root stages, 32 colatitude CORDIC stages, 4 scale/address stages.
// Throughput: one request per cycle; the whole pipeline advances together and holds
//   while a result waits on m_ready.
// Reset (aresetn low, synchronous) clears all valid bits and loads the registers
//   to width 2048, height 1024, pitch 8192.
module equirect_to_cubemap_lookup_unit #(
    parameter int FACE_SIZE  = e2c_pkg::FACE_SIZE_DEF,
    parameter int ANGLE_BITS = e2c_pkg::ANGLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  e2c_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output e2c_pkg::out_t                  m_data,
    input  logic                           cfg_we,
    input  logic [e2c_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [e2c_pkg::CFG_DATA_W-1:0] cfg_data
);
    import e2c_pkg::*;

    localparam int AB  = ANGLE_BITS;
    localparam int LAT = 2 + ISQ_STEPS + CORDIC_LAT + 4;
    localparam logic signed [VEC_W-1:0] FS = VEC_W'(FACE_SIZE);
    localparam logic [DEST_W-1:0] DEST_PITCH = DEST_W'(FACE_SIZE * PIXEL_BYTES);

    logic                en;
    logic [LAT-1:0]      vld_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [PITCH_W-1:0]  pitch_reg;

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en && aresetn;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            width_reg  <= WIDTH_W'(2048);
            height_reg <= HEIGHT_W'(1024);
            pitch_reg  <= PITCH_W'(8192);
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_valid};
            end
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SRC_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                    CFG_SRC_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                    CFG_SRC_PITCH:  pitch_reg  <= cfg_data[PITCH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // face direction vector
    logic signed [VEC_W-1:0] a_c, b_c, x_next, y_next, z_next;
    logic signed [VEC_W-1:0] vx_reg, vy_reg, vz_reg;
    logic [DEST_W-1:0]       dest_next, dest_reg;

    assign a_c = $signed({{(VEC_W-COL_W-1){1'b0}}, s_data.col, 1'b0}) - FS;
    assign b_c = $signed({{(VEC_W-COL_W-1){1'b0}}, s_data.row, 1'b0}) - FS;
    assign dest_next = (DEST_W'(s_data.col) << 2) + DEST_W'(s_data.row) * DEST_PITCH;

    always_comb begin
        case (s_data.face)
            FACE_NX: begin x_next = -FS;  y_next = -b_c; z_next = a_c;  end
            FACE_PY: begin x_next = a_c;  y_next = FS;   z_next = b_c;  end
            FACE_NY: begin x_next = a_c;  y_next = -FS;  z_next = -b_c; end
            FACE_PZ: begin x_next = a_c;  y_next = -b_c; z_next = FS;   end
            FACE_NZ: begin x_next = -a_c; y_next = -b_c; z_next = -FS;  end
            default: begin x_next = FS;   y_next = -b_c; z_next = -a_c; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vx_reg   <= x_next;
            vy_reg   <= y_next;
            vz_reg   <= z_next;
            dest_reg <= dest_next;
        end
    end

    // horizontal radius squared
    logic signed [2*VEC_W:0] sq_c;
    logic [SQ_W-1:0]         sq_reg;
    assign sq_c = (2*VEC_W+1)'(vx_reg) * (2*VEC_W+1)'(vx_reg)
                + (2*VEC_W+1)'(vz_reg) * (2*VEC_W+1)'(vz_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= sq_c[SQ_W-1:0];
        end
    end

    logic [ROOT_W-1:0] root;
    e2c_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .rad  ({sq_reg, 16'b0}),
        .root (root)
    );

    // y waits for the root
    logic [VEC_W-1:0] y_dly;
    e2c_delay #(.W(VEC_W), .DEPTH(1 + ISQ_STEPS)) u_y_dly (
        .aclk (aclk),
        .en   (en),
        .d    (vy_reg),
        .q    (y_dly)
    );

    logic signed [CORDIC_W-1:0] lon_x, lon_z, col_x, col_y;
    logic [31:0] lon_ang, col_ang, lon_dly;

    assign lon_x = CORDIC_W'(vx_reg) <<< 20;
    assign lon_z = CORDIC_W'(vz_reg) <<< 20;
    assign col_x = CORDIC_W'($signed({1'b0, root})) <<< 11;
    assign col_y = CORDIC_W'($signed(y_dly)) <<< 19;

    e2c_cordic u_lon (
        .aclk (aclk),
        .en   (en),
        .x_in (lon_x),
        .y_in (lon_z),
        .ang  (lon_ang)
    );

    e2c_cordic u_colat (
        .aclk (aclk),
        .en   (en),
        .x_in (col_x),
        .y_in (col_y),
        .ang  (col_ang)
    );

    e2c_delay #(.W(32), .DEPTH(1 + ISQ_STEPS)) u_lon_dly (
        .aclk (aclk),
        .en   (en),
        .d    (lon_ang),
        .q    (lon_dly)
    );

    logic [DEST_W-1:0] dest_dly;
    e2c_delay #(.W(DEST_W), .DEPTH(LAT - 2)) u_dest_dly (
        .aclk (aclk),
        .en   (en),
        .d    (dest_reg),
        .q    (dest_dly)
    );

    // colatitude = quarter turn minus elevation, clamped to [0, half turn]
    logic signed [33:0] colat_c;
    logic [31:0]        colat_clamp;
    logic [AB:0]        colf_reg;
    logic [AB-1:0]      lonf_reg;

    assign colat_c = 34'sh0_4000_0000 - 34'($signed(col_ang));

    always_comb begin
        if (colat_c < 0) begin
            colat_clamp = '0;
        end else if (colat_c > 34'sh0_8000_0000) begin
            colat_clamp = 32'h8000_0000;
        end else begin
            colat_clamp = colat_c[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            colf_reg <= colat_clamp[31:31-AB];
            lonf_reg <= lon_dly[31:32-AB];
        end
    end

    logic [WIDTH_W+AB-1:0]  px_reg;
    logic [HEIGHT_W+AB:0]   py_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= width_reg * lonf_reg;
            py_reg <= height_reg * colf_reg;
        end
    end

    // pole clamp
    logic [HEIGHT_W:0]  sy_full;
    logic [HEIGHT_W:0]  sy_c;
    logic [SRCX_W-1:0]  sx_reg;
    logic [SRCY_W-1:0]  sy_reg;

    assign sy_full = py_reg[HEIGHT_W+AB:AB];

    always_comb begin
        if ((height_reg != '0) && (sy_full > {1'b0, height_reg - HEIGHT_W'(1)})) begin
            sy_c = {1'b0, height_reg - HEIGHT_W'(1)};
        end else begin
            sy_c = sy_full;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg <= px_reg[AB+SRCX_W-1:AB];
            sy_reg <= sy_c[SRCY_W-1:0];
        end
    end

    logic [SRCY_W+PITCH_W-1:0] row_off;
    out_t                      out_reg;
    assign row_off = sy_reg * pitch_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.src_x       <= sx_reg;
            out_reg.src_y       <= sy_reg;
            out_reg.src_address <= (ADDR_W'(sx_reg) << 2) + row_off[ADDR_W-1:0];
            out_reg.dest_offset <= dest_dly;
        end
    end

    assign m_data = out_reg;
endmodule
